// ===== src/sync_len_checksum_frame_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// sync_len_checksum_frame_parser_core_macros
// assertion macros shared by the frame parser modules
// ----------------------------------------------------------------------------
`ifndef SYNC_LEN_CHECKSUM_FRAME_PARSER_CORE_MACROS_SVH
`define SYNC_LEN_CHECKSUM_FRAME_PARSER_CORE_MACROS_SVH

`ifndef SYNTH

// plain property, checked every cycle out of reset
`define SLCP_ASSERT(LBL, C, R, P) \
  LBL: assert property (@(posedge C) disable iff (!R) (P)) \
    else $error("slcp assertion failed");

// same-cycle implication
`define SLCP_ASSERT_IMP(LBL, C, R, A, P) \
  LBL: assert property (@(posedge C) disable iff (!R) (A) |-> (P)) \
    else $error("slcp implication failed");

`else

`define SLCP_ASSERT(LBL, C, R, P)
`define SLCP_ASSERT_IMP(LBL, C, R, A, P)

`endif

`endif

// ===== src/slcp_pkg.sv =====
// ----------------------------------------------------------------------------
// slcp_pkg
// types and constants of the sync/length/checksum frame parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slcp_pkg;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_CMD   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_SUM   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ACT_OTHER = 3'd0,
    ACT_ESTOP = 3'd1,
    ACT_IDLE  = 3'd2,
    ACT_JOB   = 3'd3,
    ACT_CAL   = 3'd4
  } action_t;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 8'd1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hBB;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h66;

  localparam logic [7:0] CMD_ESTOP = 8'hEE;
  localparam logic [7:0] CMD_IDLE  = 8'hFF;
  localparam logic [7:0] CMD_JOB   = 8'h10;
  localparam logic [7:0] CMD_CAL   = 8'h20;
  localparam logic [7:0] LEN_JOB   = 8'd14;
  localparam logic [7:0] LEN_CAL   = 8'd4;

  // one checked frame handed from front to back
  typedef struct packed {
    logic       valid;
    logic       bank;
    logic [7:0] command;
    action_t    action;
    logic [7:0] length;
  } desc_t;

  // back end occupancy seen by the front end
  typedef struct packed {
    logic desc_full;
    logic busy;
    logic bank;
  } back_stat_t;

  typedef struct packed {
    logic [7:0] command;
    action_t    action;
    logic       has_payload;
    logic [4:0] byte_index;
    logic [7:0] payload_byte;
    logic       last;
  } result_t;

  function automatic action_t classify(input logic [7:0] cmd, input logic [7:0] len);
    action_t act;
    priority if (cmd == CMD_ESTOP)                  act = ACT_ESTOP;
    else if (cmd == CMD_IDLE)                       act = ACT_IDLE;
    else if (cmd == CMD_JOB && len == LEN_JOB)      act = ACT_JOB;
    else if (cmd == CMD_CAL && len == LEN_CAL)      act = ACT_CAL;
    else                                            act = ACT_OTHER;
    return act;
  endfunction

endpackage

// ===== src/slcp_ram.sv =====
// ----------------------------------------------------------------------------
// slcp_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/slcp_front.sv =====
// ----------------------------------------------------------------------------
// slcp_front
// byte parser: header hunt, command, length, payload capture and checksum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slcp_front #(
  parameter int MAX_PAYLOAD = 20,
  parameter int IW          = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic [7:0]                     in_rx_byte,
  output logic                           in_full,
  input  logic                           cfg_we,
  input  logic [slcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  slcp_pkg::back_stat_t           stat,
  output slcp_pkg::desc_t                desc,
  output logic                           ram_we,
  output logic [IW:0]                    ram_waddr,
  output logic [7:0]                     ram_wdata
);

  localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);

  slcp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] sync_first_r, sync_first_nxt;
  logic [7:0] sync_second_r, sync_second_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] taken_r, taken_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       wr_bank_r, wr_bank_nxt;
  logic       accept;
  logic       len_big;
  logic [8:0] taken_inc;

  assign accept    = in_push & ~in_full;
  assign len_big   = {1'b0, in_rx_byte} > MAX_LEN;
  assign taken_inc = {1'b0, taken_r} + 9'd1;

  // both payload banks held while the back end drains, or no slot for a frame
  assign in_full = (phase_r == slcp_pkg::PH_DATA && stat.desc_full && stat.busy) ||
                   (phase_r == slcp_pkg::PH_SUM && stat.desc_full);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        slcp_pkg::PH_HUNT2: begin
          if (in_rx_byte == sync_second_r) phase_nxt = slcp_pkg::PH_CMD;
          else if (in_rx_byte == sync_first_r) phase_nxt = slcp_pkg::PH_HUNT2;
          else phase_nxt = slcp_pkg::PH_HUNT1;
        end
        slcp_pkg::PH_CMD: phase_nxt = slcp_pkg::PH_LEN;
        slcp_pkg::PH_LEN: begin
          if (len_big) phase_nxt = slcp_pkg::PH_HUNT1;
          else if (in_rx_byte != 8'd0) phase_nxt = slcp_pkg::PH_DATA;
          else phase_nxt = slcp_pkg::PH_SUM;
        end
        slcp_pkg::PH_DATA: begin
          if (taken_inc >= {1'b0, len_r}) phase_nxt = slcp_pkg::PH_SUM;
        end
        slcp_pkg::PH_SUM: phase_nxt = slcp_pkg::PH_HUNT1;
        default: begin
          phase_nxt = (in_rx_byte == sync_first_r) ? slcp_pkg::PH_HUNT2
                                                   : slcp_pkg::PH_HUNT1;
        end
      endcase
    end
  end

  // outputs and frame registers
  always_comb begin
    cmd_nxt         = cmd_r;
    len_nxt         = len_r;
    taken_nxt       = taken_r;
    sum_nxt         = sum_r;
    wr_bank_nxt     = wr_bank_r;
    sync_first_nxt  = sync_first_r;
    sync_second_nxt = sync_second_r;
    ram_we          = 1'b0;
    ram_waddr       = {wr_bank_r, taken_r[IW-1:0]};
    ram_wdata       = in_rx_byte;
    desc            = '0;
    desc.bank       = wr_bank_r;
    desc.command    = cmd_r;
    desc.action     = slcp_pkg::classify(cmd_r, len_r);
    desc.length     = len_r;

    if (cfg_we) begin
      priority if (cfg_index == slcp_pkg::REG_SYNC_FIRST) sync_first_nxt = cfg_data;
      else if (cfg_index == slcp_pkg::REG_SYNC_SECOND) sync_second_nxt = cfg_data;
      else sync_first_nxt = sync_first_r;
    end

    if (accept) begin
      unique case (phase_r)
        slcp_pkg::PH_CMD: begin
          cmd_nxt = in_rx_byte;
          sum_nxt = in_rx_byte;
        end
        slcp_pkg::PH_LEN: begin
          sum_nxt   = sum_r + in_rx_byte;
          taken_nxt = 8'd0;
          if (!len_big) len_nxt = in_rx_byte;
        end
        slcp_pkg::PH_DATA: begin
          ram_we    = 1'b1;
          taken_nxt = taken_r + 8'd1;
          sum_nxt   = sum_r + in_rx_byte;
        end
        slcp_pkg::PH_SUM: begin
          if (sum_r == in_rx_byte) begin
            desc.valid  = 1'b1;
            wr_bank_nxt = ~wr_bank_r;
          end
        end
        default: begin
          cmd_nxt = cmd_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= slcp_pkg::PH_HUNT1;
      sync_first_r  <= slcp_pkg::SYNC_FIRST_RST;
      sync_second_r <= slcp_pkg::SYNC_SECOND_RST;
      cmd_r         <= 8'd0;
      len_r         <= 8'd0;
      taken_r       <= 8'd0;
      sum_r         <= 8'd0;
      wr_bank_r     <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      sync_first_r  <= sync_first_nxt;
      sync_second_r <= sync_second_nxt;
      cmd_r         <= cmd_nxt;
      len_r         <= len_nxt;
      taken_r       <= taken_nxt;
      sum_r         <= sum_nxt;
      wr_bank_r     <= wr_bank_nxt;
    end
  end

endmodule

// ===== src/slcp_back.sv =====
// ----------------------------------------------------------------------------
// slcp_back
// frame slot, payload readout and result queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_len_checksum_frame_parser_core_macros.svh"

module slcp_back #(
  parameter int IW = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slcp_pkg::desc_t      desc,
  output slcp_pkg::back_stat_t stat,
  output logic                 ram_re,
  output logic [IW:0]          ram_raddr,
  input  logic [7:0]           ram_rdata,
  input  logic                 out_pop,
  output logic                 out_empty,
  output slcp_pkg::result_t    out_res
);

  localparam int OUT_DEPTH = 4;
  localparam int PW        = $clog2(OUT_DEPTH);
  localparam int CW        = $clog2(OUT_DEPTH + 1);

  slcp_pkg::desc_t   dq_r, dq_nxt;
  logic              busy_r, busy_nxt;
  logic              bank_r, bank_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  slcp_pkg::action_t act_r, act_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        idx_r, idx_nxt;
  slcp_pkg::result_t fl_r, fl_nxt;
  logic              fl_valid_r;
  slcp_pkg::result_t mem_r [OUT_DEPTH];
  slcp_pkg::result_t wr_res;
  logic [PW-1:0]     wp_r, rp_r;
  logic [CW-1:0]     cnt_r;
  logic [CW:0]       fill_lvl;
  logic              load, issue, is_last, push, pop;

  assign stat      = '{desc_full: dq_r.valid, busy: busy_r, bank: bank_r};
  assign load      = ~busy_r & dq_r.valid;
  // keep room for the word still in the ram read stage
  assign fill_lvl  = {1'b0, cnt_r} + {{CW{1'b0}}, fl_valid_r};
  assign issue     = busy_r && (fill_lvl < (CW + 1)'(OUT_DEPTH));
  assign is_last   = (len_r == 8'd0) || ((idx_r + 8'd1) == len_r);
  assign ram_re    = issue;
  assign ram_raddr = {bank_r, idx_r[IW-1:0]};
  assign push      = fl_valid_r;
  assign pop       = out_pop & ~out_empty;
  assign out_empty = (cnt_r == '0);
  assign out_res   = mem_r[rp_r];

  always_comb begin
    dq_nxt   = dq_r;
    busy_nxt = busy_r;
    bank_nxt = bank_r;
    cmd_nxt  = cmd_r;
    act_nxt  = act_r;
    len_nxt  = len_r;
    idx_nxt  = idx_r;
    fl_nxt   = fl_r;

    if (desc.valid) begin
      dq_nxt = desc;
    end else if (load) begin
      dq_nxt.valid = 1'b0;
    end

    if (load) begin
      busy_nxt = 1'b1;
      bank_nxt = dq_r.bank;
      cmd_nxt  = dq_r.command;
      act_nxt  = dq_r.action;
      len_nxt  = dq_r.length;
      idx_nxt  = 8'd0;
    end else if (issue) begin
      idx_nxt  = idx_r + 8'd1;
      if (is_last) busy_nxt = 1'b0;
      fl_nxt.command      = cmd_r;
      fl_nxt.action       = act_r;
      fl_nxt.has_payload  = (len_r != 8'd0);
      fl_nxt.byte_index   = idx_r[4:0];
      fl_nxt.payload_byte = 8'd0;
      fl_nxt.last         = is_last;
    end

    wr_res = fl_r;
    if (fl_r.has_payload) wr_res.payload_byte = ram_rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dq_r       <= '0;
      busy_r     <= 1'b0;
      fl_valid_r <= 1'b0;
      wp_r       <= '0;
      rp_r       <= '0;
      cnt_r      <= '0;
    end else begin
      dq_r       <= dq_nxt;
      busy_r     <= busy_nxt;
      fl_valid_r <= issue;
      if (push) wp_r <= wp_r + PW'(1);
      if (pop) rp_r <= rp_r + PW'(1);
      cnt_r      <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    bank_r <= bank_nxt;
    cmd_r  <= cmd_nxt;
    act_r  <= act_nxt;
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    fl_r   <= fl_nxt;
    if (push) begin
      mem_r[wp_r] <= wr_res;
    end
  end

  `SLCP_ASSERT(a_queue_bound, clk, rst_n, fill_lvl <= (CW + 1)'(OUT_DEPTH))
  `SLCP_ASSERT_IMP(a_slot_free, clk, rst_n, desc.valid, !dq_r.valid)
  `SLCP_ASSERT_IMP(a_empty_frame_single, clk, rst_n, fl_valid_r && !fl_r.has_payload, fl_r.last)

endmodule

// ===== src/sync_len_checksum_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// sync_len_checksum_frame_parser_core
// serial frame parser with header hunt, length field and additive checksum
// ----------------------------------------------------------------------------
// Input: one received byte per word on in_rx_byte, taken when in_push is
// high and in_full is low. Results: one word per payload byte of a frame
// whose checksum matched (one word for an empty frame), shown while
// out_empty is low and taken with out_pop.
// Configuration: cfg_index 0 sets the first header byte, 1 the second; the
// port is always ready and other indexes are dropped. Write while idle.
// Throughput: one byte per cycle on the input and up to one result per
// cycle on the output. Payload lives in two banks of a dual port ram, so
// the parser runs one frame ahead of the readout; it holds in_full only
// when it would overwrite a bank still being read or no frame slot is free.
// Path: after its checksum byte is taken, the first result of a frame passes
// the slot load, the ram read and the result queue before it is visible.
// Stalls: out_pop held low fills the four-word result queue, then the readout
// waits, and then the parser as above. Reset returns to header hunt with
// the default header bytes and empties every queue; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_len_checksum_frame_parser_core_macros.svh"

module sync_len_checksum_frame_parser_core #(
  parameter int MAX_PAYLOAD = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [7:0]                     out_command,
  output logic [2:0]                     out_action,
  output logic                           out_has_payload,
  output logic [4:0]                     out_byte_index,
  output logic [7:0]                     out_payload_byte,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [slcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  slcp_pkg::desc_t      desc;
  slcp_pkg::back_stat_t stat;
  slcp_pkg::result_t    res;
  logic                 ram_we, ram_re;
  logic [IW:0]          ram_waddr, ram_raddr;
  logic [7:0]           ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  slcp_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .IW          (IW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .stat       (stat),
    .desc       (desc),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  slcp_ram #(
    .WIDTH (8),
    .DEPTH (2 ** (IW + 1))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  slcp_back #(
    .IW (IW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .desc      (desc),
    .stat      (stat),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (res)
  );

  assign out_command      = res.command;
  assign out_action       = res.action;
  assign out_has_payload  = res.has_payload;
  assign out_byte_index   = res.byte_index;
  assign out_payload_byte = res.payload_byte;
  assign out_last         = res.last;

  // the parser never writes the bank that the readout is draining
  `SLCP_ASSERT_IMP(a_bank_apart, clk, rst_n, ram_we && stat.busy, ram_waddr[IW] != stat.bank)

endmodule

// ===== bench/sync_len_checksum_frame_parser_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_len_checksum_frame_parser_core_tb
// self-checking bench for the header/length/checksum frame parser
// ----------------------------------------------------------------------------
// Drives byte streams into the parser, tracks the parse state of every taken
// byte in a local model and compares each popped result word, field by field,
// with the words that model expects. Covers empty and full-length frames,
// every action class, oversize lengths, bad checksums, header hunting with
// repeated and equal header bytes, header register changes and a long
// output stall that backs the parser up.
// ----------------------------------------------------------------------------
module sync_len_checksum_frame_parser_core_tb;

  localparam int MAX_LEN       = 20;
  localparam int RANDOM_BYTES  = 75;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 300;
  localparam logic [slcp_pkg::CFG_IDX_W-1:0] REG_NONE = 8'hFF;

  typedef logic [7:0] byte_q_t[$];

  logic                           clk;
  logic                           rst_n            = 1'b0;
  logic                           in_push          = 1'b0;
  logic                           in_full;
  logic [7:0]                     in_rx_byte       = 8'h00;
  logic                           out_empty;
  logic                           out_pop          = 1'b0;
  logic [7:0]                     out_command;
  logic [2:0]                     out_action;
  logic                           out_has_payload;
  logic [4:0]                     out_byte_index;
  logic [7:0]                     out_payload_byte;
  logic                           out_last;
  logic                           cfg_valid        = 1'b0;
  logic                           cfg_ready;
  logic [slcp_pkg::CFG_IDX_W-1:0] cfg_index        = '0;
  logic [7:0]                     cfg_data         = 8'h00;

  // parse state mirrored from the taken byte stream
  slcp_pkg::phase_t  parse_phase = slcp_pkg::PH_HUNT1;
  logic [7:0]        hdr_first   = slcp_pkg::SYNC_FIRST_RST;
  logic [7:0]        hdr_second  = slcp_pkg::SYNC_SECOND_RST;
  logic [7:0]        cur_cmd     = 8'h00;
  logic [7:0]        cur_len     = 8'h00;
  logic [4:0]        taken       = 5'd0;
  logic [7:0]        csum        = 8'h00;
  logic [7:0]        payload_mem [MAX_LEN];
  slcp_pkg::result_t frame_words_due[$];

  int         error_count   = 0;
  int         cycle_count   = 0;
  int         bytes_sent    = 0;
  int         burst_left    = 0;
  bit         sender_gaps   = 1'b1;
  int         hold_left     = 0;
  int         pattern_age   = 0;
  logic [15:0] stall_pattern = 16'hFFFF;

  sync_len_checksum_frame_parser_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_rx_byte       (in_rx_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_command      (out_command),
    .out_action       (out_action),
    .out_has_payload  (out_has_payload),
    .out_byte_index   (out_byte_index),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic slcp_pkg::action_t action_of(input logic [7:0] cmd,
                                                  input logic [7:0] len);
    slcp_pkg::action_t act;
    if (cmd == slcp_pkg::CMD_ESTOP) begin
      act = slcp_pkg::ACT_ESTOP;
    end else if (cmd == slcp_pkg::CMD_IDLE) begin
      act = slcp_pkg::ACT_IDLE;
    end else if (cmd == slcp_pkg::CMD_JOB && len == slcp_pkg::LEN_JOB) begin
      act = slcp_pkg::ACT_JOB;
    end else if (cmd == slcp_pkg::CMD_CAL && len == slcp_pkg::LEN_CAL) begin
      act = slcp_pkg::ACT_CAL;
    end else begin
      act = slcp_pkg::ACT_OTHER;
    end
    return act;
  endfunction

  // advance the parse state by one taken byte, queue the words it releases
  function automatic void parse_rx_byte(input logic [7:0] b);
    slcp_pkg::result_t w;
    int                n;
    case (parse_phase)
      slcp_pkg::PH_HUNT2: begin
        if (b == hdr_second) begin
          parse_phase = slcp_pkg::PH_CMD;
        end else if (b == hdr_first) begin
          parse_phase = slcp_pkg::PH_HUNT2;
        end else begin
          parse_phase = slcp_pkg::PH_HUNT1;
        end
      end
      slcp_pkg::PH_CMD: begin
        cur_cmd     = b;
        csum        = b;
        parse_phase = slcp_pkg::PH_LEN;
      end
      slcp_pkg::PH_LEN: begin
        csum  = csum + b;
        taken = 5'd0;
        if (b > MAX_LEN) begin
          parse_phase = slcp_pkg::PH_HUNT1;
        end else begin
          cur_len     = b;
          parse_phase = (b != 8'd0) ? slcp_pkg::PH_DATA : slcp_pkg::PH_SUM;
        end
      end
      slcp_pkg::PH_DATA: begin
        if (taken < MAX_LEN) payload_mem[taken] = b;
        taken = taken + 5'd1;
        csum  = csum + b;
        if (taken >= cur_len) parse_phase = slcp_pkg::PH_SUM;
      end
      slcp_pkg::PH_SUM: begin
        if (csum == b) begin
          // an empty frame still releases one word
          n = (cur_len == 8'd0) ? 1 : int'(cur_len);
          for (int i = 0; i < n; i++) begin
            w.command      = cur_cmd;
            w.action       = action_of(cur_cmd, cur_len);
            w.has_payload  = (cur_len != 8'd0);
            w.byte_index   = w.has_payload ? 5'(i) : 5'd0;
            w.payload_byte = w.has_payload ? payload_mem[i] : 8'h00;
            w.last         = (i == n - 1);
            frame_words_due.push_back(w);
          end
        end
        parse_phase = slcp_pkg::PH_HUNT1;
      end
      default: begin
        parse_phase = (b == hdr_first) ? slcp_pkg::PH_HUNT2 : slcp_pkg::PH_HUNT1;
      end
    endcase
  endfunction

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic byte_q_t random_payload(input int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_gaps && $urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_push = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_push    = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (in_full);
    parse_rx_byte(b);
    burst_left--;
    bytes_sent++;
  endtask

  // header, command, length, data, then checksum offset by sum_skew
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                            input byte_q_t data, input logic [7:0] sum_skew);
    logic [7:0] sum;
    sum = cmd + len;
    send_rx_byte(hdr_first);
    send_rx_byte(hdr_second);
    send_rx_byte(cmd);
    send_rx_byte(len);
    foreach (data[i]) begin
      send_rx_byte(data[i]);
      sum = sum + data[i];
    end
    send_rx_byte(sum + sum_skew);
  endtask

  // registers change only once the parser has drained
  task automatic write_reg(input logic [slcp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] data);
    @(negedge clk);
    in_push    = 1'b0;
    burst_left = 0;
    while (frame_words_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == slcp_pkg::REG_SYNC_FIRST) begin
      hdr_first = data;
    end else if (idx == slcp_pkg::REG_SYNC_SECOND) begin
      hdr_second = data;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_header(input logic [7:0] first, input logic [7:0] second);
    write_reg(slcp_pkg::REG_SYNC_FIRST, first);
    write_reg(slcp_pkg::REG_SYNC_SECOND, second);
  endtask

  task automatic test_frame_basics();
    send_frame(8'h00, 8'd0, random_payload(0), 8'h00);
    send_frame(slcp_pkg::CMD_IDLE, 8'd3, '{8'h00, 8'hFF, 8'h7F}, 8'h00);
    send_frame(slcp_pkg::CMD_ESTOP, 8'd1, '{8'h80}, 8'h00);
    send_frame(slcp_pkg::CMD_ESTOP, 8'd0, random_payload(0), 8'h00);
  endtask

  task automatic test_action_classes();
    send_frame(slcp_pkg::CMD_JOB, slcp_pkg::LEN_JOB,
               random_payload(slcp_pkg::LEN_JOB), 8'h00);
    send_frame(slcp_pkg::CMD_CAL, slcp_pkg::LEN_CAL,
               random_payload(slcp_pkg::LEN_CAL), 8'h00);
    // matching command with the wrong length falls back to other
    send_frame(slcp_pkg::CMD_JOB, slcp_pkg::LEN_CAL,
               random_payload(slcp_pkg::LEN_CAL), 8'h00);
    send_frame(slcp_pkg::CMD_CAL, 8'd3, random_payload(3), 8'h00);
    send_frame(slcp_pkg::CMD_JOB, 8'd0, random_payload(0), 8'h00);
  endtask

  task automatic test_length_limits();
    send_frame(8'h5A, 8'(MAX_LEN), random_payload(MAX_LEN), 8'h00);
    send_frame(8'h33, 8'(MAX_LEN + 1), random_payload(3), 8'h00);
    send_frame(8'hC3, 8'hFF, random_payload(2), 8'h00);
    send_frame(8'h01, 8'd2, random_payload(2), 8'h00);
  endtask

  task automatic test_bad_checksum();
    send_frame(8'h42, 8'd2, random_payload(2), 8'h01);
    send_frame(slcp_pkg::CMD_ESTOP, 8'd0, random_payload(0), 8'h80);
    send_frame(8'h42, 8'd1, random_payload(1), 8'h00);
  endtask

  task automatic test_header_hunt();
    // repeated first header bytes keep the partial match
    repeat (3) send_rx_byte(hdr_first);
    send_frame(8'h77, 8'd1, random_payload(1), 8'h00);
    send_rx_byte(hdr_first);
    send_rx_byte(~hdr_second);
    send_rx_byte(hdr_second);
    send_frame(8'h78, 8'd2, random_payload(2), 8'h00);
  endtask

  task automatic test_header_config();
    set_header(8'h00, 8'hFF);
    send_frame(8'h11, 8'd2, random_payload(2), 8'h00);
    set_header(8'hFF, 8'h00);
    send_frame(8'h12, 8'd1, random_payload(1), 8'h00);
    // equal header bytes: the second match wins over a restart
    set_header(8'h5A, 8'h5A);
    send_frame(8'h13, 8'd1, random_payload(1), 8'h00);
    send_rx_byte(8'h5A);
    send_frame(8'h14, 8'd0, random_payload(0), 8'h00);
    write_reg(REG_NONE, 8'($urandom));
    send_frame(8'h15, 8'd1, random_payload(1), 8'h00);
    set_header(slcp_pkg::SYNC_FIRST_RST, slcp_pkg::SYNC_SECOND_RST);
    send_frame(8'h16, 8'd1, random_payload(1), 8'h00);
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_left   = LONG_HOLD;
    sender_gaps = 1'b0;
    repeat (4) send_frame(8'($urandom), 8'(MAX_LEN), random_payload(MAX_LEN), 8'h00);
    sender_gaps = 1'b1;
  endtask

  task automatic test_random();
    int         done;
    int         since_cfg;
    int         kind;
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] first;
    done      = 0;
    since_cfg = 0;
    while (done < RANDOM_BYTES) begin
      if (since_cfg > 100) begin
        first = 8'($urandom);
        set_header(first, ($urandom_range(0, 5) == 0) ? first : 8'($urandom));
        since_cfg = 0;
      end
      case ($urandom_range(0, 5))
        0:       cmd = slcp_pkg::CMD_ESTOP;
        1:       cmd = slcp_pkg::CMD_IDLE;
        2:       cmd = slcp_pkg::CMD_JOB;
        3:       cmd = slcp_pkg::CMD_CAL;
        default: cmd = 8'($urandom);
      endcase
      if (cmd == slcp_pkg::CMD_JOB && $urandom_range(0, 1) == 1) begin
        len = slcp_pkg::LEN_JOB;
      end else if (cmd == slcp_pkg::CMD_CAL && $urandom_range(0, 1) == 1) begin
        len = slcp_pkg::LEN_CAL;
      end else if ($urandom_range(0, 4) == 0) begin
        len = 8'($urandom_range(0, MAX_LEN));
      end else begin
        len = 8'($urandom_range(0, 6));
      end
      kind = $urandom_range(0, 99);
      if (kind < 76) begin
        send_frame(cmd, len, random_payload(len), 8'h00);
      end else if (kind < 86) begin
        send_frame(cmd, len, random_payload(len), 8'($urandom_range(1, 255)));
      end else if (kind < 93) begin
        len = 8'($urandom_range(MAX_LEN + 1, 255));
        send_frame(cmd, len, random_payload($urandom_range(0, 4)), 8'h00);
        len = 8'd0;
      end else begin
        // line noise, partly made of first header bytes
        repeat ($urandom_range(1, 6))
          send_rx_byte(($urandom_range(0, 2) == 0) ? hdr_first : 8'($urandom));
        len = 8'd0;
      end
      done      += int'(len) + 5;
      since_cfg += int'(len) + 5;
    end
  endtask

  // result side: a random pop pattern, renewed when its age runs out, long hold on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_pop = 1'b0;
      hold_left--;
    end else begin
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern = 16'hFFFF;
          1:       stall_pattern = 16'($urandom);
          2:       stall_pattern = 16'hAAAA;
          default: stall_pattern = 16'h8421;
        endcase
        pattern_age = $urandom_range(16, 80);
      end
      pattern_age--;
      out_pop       = stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  always @(posedge clk) begin : check_words
    slcp_pkg::result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (frame_words_due.size() == 0) begin
        log_error($sformatf("unexpected word: cmd %h act %0d idx %0d data %h last %0b",
                            out_command, out_action, out_byte_index, out_payload_byte,
                            out_last));
      end else begin
        want = frame_words_due.pop_front();
        if (out_command !== want.command || out_action !== want.action ||
            out_has_payload !== want.has_payload || out_byte_index !== want.byte_index ||
            out_payload_byte !== want.payload_byte || out_last !== want.last) begin
          log_error($sformatf({"word mismatch: expected cmd %h act %0d has %0b idx %0d ",
                               "data %h last %0b, got cmd %h act %0d has %0b idx %0d ",
                               "data %h last %0b"},
                              want.command, want.action, want.has_payload, want.byte_index,
                              want.payload_byte, want.last, out_command, out_action,
                              out_has_payload, out_byte_index, out_payload_byte, out_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_frame_basics();
    test_action_classes();
    test_length_limits();
    test_bad_checksum();
    test_header_hunt();
    test_header_config();
    test_backpressure();
    test_random();

    @(negedge clk);
    in_push = 1'b0;
    while (frame_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
